[hw/rtl/mp2d_pkg.sv]
// ----------------------------------------------------------------------------
// mp2d_pkg
// Shared types and constants of the 2-D max pooling block: configuration
// register indexes and widths, reset values, and controller/datapath links.
// ----------------------------------------------------------------------------
package mp2d_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CFG_INDEX_W-1:0] REG_POOL_SIDE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_SIZE    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IN_HEIGHT    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_IN_WIDTH     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_NUM_CHANNELS = 3'd4;

  localparam int POOL_REG_W  = 3;
  localparam int STEP_REG_W  = 3;
  localparam int HEIGHT_REG_W = 9;
  localparam int WIDTH_REG_W = 8;
  localparam int CHAN_REG_W  = 5;

  localparam logic [POOL_REG_W-1:0]   POOL_RESET   = 3'd2;
  localparam logic [STEP_REG_W-1:0]   STEP_RESET   = 3'd2;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 9'd8;
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 8'd8;
  localparam logic [CHAN_REG_W-1:0]   CHAN_RESET   = 5'd1;

  localparam int STEP_LIMIT   = 4;
  localparam int HEIGHT_LIMIT = 256;
  localparam int ROW_W        = 8;
  localparam int PHASE_W      = 2;

  typedef struct packed {
    logic accept;
    logic read_issue;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic rd_last;
    logic out_free;
  } status_t;

  function automatic logic [31:0] clamp_reg(input logic [31:0] v, input logic [31:0] hi);
    logic [31:0] r;
    if (v == 32'd0) begin
      r = 32'd1;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[hw/rtl/mp2d_ram.sv]
// ----------------------------------------------------------------------------
// mp2d_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mp2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/mp2d_ctrl.sv]
// ----------------------------------------------------------------------------
// mp2d_ctrl
// Controller of the pooling block: accepts samples, sequences the window
// reads and hands the finished maximum to the output register.
// ----------------------------------------------------------------------------
module mp2d_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mp2d_pkg::status_t status,
  output mp2d_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    IDLE,
    READ,
    DRAIN,
    EMIT
  } state_t;

  state_t state;

  always_comb begin
    in_ready       = (state == IDLE);
    cmd.accept     = (state == IDLE) && in_valid;
    cmd.read_issue = (state == READ);
    cmd.emit       = (state == EMIT) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid && status.hit) begin
            state <= READ;
          end
        end
        READ: begin
          if (status.rd_last) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          state <= EMIT;
        end
        EMIT: begin
          if (status.out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/mp2d_dp.sv]
// ----------------------------------------------------------------------------
// mp2d_dp
// Datapath of the pooling block: configuration registers, position counters,
// line store addressing, running maximum and the output register.
// ----------------------------------------------------------------------------
module mp2d_dp #(
  parameter int MAX_POOL     = 4,
  parameter int MAX_WIDTH    = 128,
  parameter int MAX_CHANNELS = 16,
  parameter int DATA_WIDTH   = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mp2d_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mp2d_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [DATA_WIDTH-1:0]            sample,
  input  mp2d_pkg::cmd_t                   cmd,
  output mp2d_pkg::status_t                status,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [DATA_WIDTH-1:0]            out_data,
  output logic                             out_last
);

  localparam int DEPTH = MAX_POOL * MAX_WIDTH * MAX_CHANNELS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLW   = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
  localparam int COLW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int PW    = $clog2(MAX_POOL + 1);

  logic [mp2d_pkg::POOL_REG_W-1:0]   pool_reg;
  logic [mp2d_pkg::STEP_REG_W-1:0]   step_reg;
  logic [mp2d_pkg::HEIGHT_REG_W-1:0] height_reg;
  logic [mp2d_pkg::WIDTH_REG_W-1:0]  width_reg;
  logic [mp2d_pkg::CHAN_REG_W-1:0]   chan_reg;

  logic [mp2d_pkg::ROW_W-1:0]   row_count, row_count_next;
  logic [COLW-1:0]              col_count, col_count_next;
  logic [CHW-1:0]               chan_count, chan_count_next;
  logic [SLW-1:0]               row_slot, row_slot_next;
  logic [mp2d_pkg::PHASE_W-1:0] row_phase, row_phase_next;
  logic [mp2d_pkg::PHASE_W-1:0] col_phase, col_phase_next;

  logic [31:0] p32, s32, h32, w32, nc32;
  logic [31:0] r32, c32, ch32, rn32, cn32, chn32;
  logic [PW-1:0] pool_eff;
  logic          hit, last_now;

  logic [SLW-1:0]  rd_slot;
  logic [COLW-1:0] rd_col, base_col;
  logic [CHW-1:0]  rd_chan;
  logic [PW-1:0]   kc, kr;
  logic            rd_pending;
  logic            last_flag;
  logic [DATA_WIDTH-1:0] best;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [AW-1:0]   wr_addr, rd_addr;
  logic            cfg_restart;

  function automatic logic [mp2d_pkg::PHASE_W-1:0] next_phase(
    input logic [31:0] pos, input logic [mp2d_pkg::PHASE_W-1:0] phase,
    input logic [31:0] p, input logic [31:0] s);
    logic [31:0] inc;
    inc = 32'(phase) + 32'd1;
    if (pos <= p - 32'd1) begin
      return '0;
    end else if (inc >= s) begin
      return '0;
    end else begin
      return mp2d_pkg::PHASE_W'(inc);
    end
  endfunction

  always_comb begin
    p32  = mp2d_pkg::clamp_reg(32'(pool_reg), 32'(MAX_POOL));
    s32  = mp2d_pkg::clamp_reg(32'(step_reg), 32'(mp2d_pkg::STEP_LIMIT));
    h32  = mp2d_pkg::clamp_reg(32'(height_reg), 32'(mp2d_pkg::HEIGHT_LIMIT));
    w32  = mp2d_pkg::clamp_reg(32'(width_reg), 32'(MAX_WIDTH));
    nc32 = mp2d_pkg::clamp_reg(32'(chan_reg), 32'(MAX_CHANNELS));
    pool_eff = PW'(p32);
    r32  = 32'(row_count);
    c32  = 32'(col_count);
    ch32 = 32'(chan_count);
    rn32 = r32 + 32'd1;
    cn32 = c32 + 32'd1;
    chn32 = ch32 + 32'd1;

    hit = (h32 >= p32) && (w32 >= p32) && (r32 >= p32 - 32'd1) && (c32 >= p32 - 32'd1) &&
          (row_phase == '0) && (col_phase == '0);
    last_now = (r32 + s32 >= h32) && (c32 + s32 >= w32) && (chn32 == nc32);

    row_count_next  = row_count;
    col_count_next  = col_count;
    chan_count_next = chan_count;
    row_slot_next   = row_slot;
    row_phase_next  = row_phase;
    col_phase_next  = col_phase;
    if (chn32 >= nc32) begin
      chan_count_next = '0;
      if (cn32 >= w32) begin
        col_count_next = '0;
        col_phase_next = '0;
        if (rn32 >= h32) begin
          row_count_next = '0;
          row_slot_next  = '0;
          row_phase_next = '0;
        end else begin
          row_count_next = mp2d_pkg::ROW_W'(rn32);
          row_slot_next  = (32'(row_slot) == 32'(MAX_POOL - 1)) ? '0 : row_slot + 1'b1;
          row_phase_next = next_phase(rn32, row_phase, p32, s32);
        end
      end else begin
        col_count_next = COLW'(cn32);
        col_phase_next = next_phase(cn32, col_phase, p32, s32);
      end
    end else begin
      chan_count_next = CHW'(chn32);
    end

    wr_addr = AW'((32'(row_slot) * MAX_WIDTH + c32) * MAX_CHANNELS + ch32);
    rd_addr = AW'((32'(rd_slot) * MAX_WIDTH + 32'(rd_col)) * MAX_CHANNELS + 32'(rd_chan));

    cfg_restart = cfg_we && (cfg_index == mp2d_pkg::REG_POOL_SIDE ||
                             cfg_index == mp2d_pkg::REG_STEP_SIZE ||
                             cfg_index == mp2d_pkg::REG_IN_HEIGHT ||
                             cfg_index == mp2d_pkg::REG_IN_WIDTH ||
                             cfg_index == mp2d_pkg::REG_NUM_CHANNELS);

    status.hit      = hit;
    status.rd_last  = (kc == pool_eff - 1'b1) && (kr == pool_eff - 1'b1);
    status.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_reg   <= mp2d_pkg::POOL_RESET;
      step_reg   <= mp2d_pkg::STEP_RESET;
      height_reg <= mp2d_pkg::HEIGHT_RESET;
      width_reg  <= mp2d_pkg::WIDTH_RESET;
      chan_reg   <= mp2d_pkg::CHAN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mp2d_pkg::REG_POOL_SIDE:    pool_reg   <= cfg_data[mp2d_pkg::POOL_REG_W-1:0];
        mp2d_pkg::REG_STEP_SIZE:    step_reg   <= cfg_data[mp2d_pkg::STEP_REG_W-1:0];
        mp2d_pkg::REG_IN_HEIGHT:    height_reg <= cfg_data[mp2d_pkg::HEIGHT_REG_W-1:0];
        mp2d_pkg::REG_IN_WIDTH:     width_reg  <= cfg_data[mp2d_pkg::WIDTH_REG_W-1:0];
        mp2d_pkg::REG_NUM_CHANNELS: chan_reg   <= cfg_data[mp2d_pkg::CHAN_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      row_count  <= '0;
      col_count  <= '0;
      chan_count <= '0;
      row_slot   <= '0;
      row_phase  <= '0;
      col_phase  <= '0;
    end else if (cmd.accept) begin
      row_count  <= row_count_next;
      col_count  <= col_count_next;
      chan_count <= chan_count_next;
      row_slot   <= row_slot_next;
      row_phase  <= row_phase_next;
      col_phase  <= col_phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_slot   <= row_slot;
      rd_col    <= col_count;
      base_col  <= col_count;
      rd_chan   <= chan_count;
      kc        <= '0;
      kr        <= '0;
      best      <= sample;
      last_flag <= last_now;
    end else begin
      if (cmd.read_issue) begin
        if (kc == pool_eff - 1'b1) begin
          kc      <= '0;
          kr      <= kr + 1'b1;
          rd_col  <= base_col;
          rd_slot <= (rd_slot == '0) ? SLW'(MAX_POOL - 1) : rd_slot - 1'b1;
        end else begin
          kc     <= kc + 1'b1;
          rd_col <= rd_col - 1'b1;
        end
      end
      if (rd_pending && ($signed(rd_data) > $signed(best))) begin
        best <= rd_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_pending <= cmd.read_issue;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= best;
      out_last <= last_flag;
    end
  end

  mp2d_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (cmd.accept),
    .wr_addr (wr_addr),
    .wr_data (sample),
    .rd_en   (cmd.read_issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

[hw/rtl/max_pool_2d_nhwc_core.sv]
// ----------------------------------------------------------------------------
// max_pool_2d_nhwc_core
// Streaming 2-D max pooling over NHWC tensors with valid windows.
//
// Samples enter on the s_axis channel in NHWC raster order, one per
// transaction, and are written to a line store holding the last MAX_POOL rows.
// When a sample closes a window, its channel's window maximum leaves on the
// m_axis channel, with tlast on the final result of the tensor.
// A sample that closes no window is taken without a stall. A sample that closes
// a window is followed by one line store read per window entry through the
// single read port, a drain state for the last read to return, and an emit
// state that loads the output register once it is free. The output register
// lets the next sample be taken while a result waits; a stalled receiver holds
// back input only once a further result is ready. The user must write registers
// on the cfg channel only while the block is idle; the block does not enforce
// this. A write to any of the five registers restarts the tensor. Reset loads
// the default registers and restarts the tensor; the line store is not cleared
// and needs no clearing pass.
// ----------------------------------------------------------------------------
module max_pool_2d_nhwc_core #(
  parameter int MAX_POOL     = 4,
  parameter int MAX_WIDTH    = 128,
  parameter int MAX_CHANNELS = 16,
  parameter int DATA_WIDTH   = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mp2d_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [mp2d_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,  // sample_value
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,  // pooled_value
  output logic                                   m_axis_tlast
);

  localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

  mp2d_pkg::cmd_t    cmd;
  mp2d_pkg::status_t status;
  logic [DATA_WIDTH-1:0] pooled;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = TDATA_W'(pooled);

  mp2d_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mp2d_dp #(
    .MAX_POOL     (MAX_POOL),
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (s_axis_tdata[DATA_WIDTH-1:0]),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (pooled),
    .out_last  (m_axis_tlast)
  );

  a_no_accept_while_reading: assert property (@(posedge clk) disable iff (rst)
    cmd.read_issue |-> !s_axis_tready)
    else $error("Input accepted during a window read.");

  a_emit_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> m_axis_tvalid)
    else $error("Emitted result missing on the output.");

  a_miss_stays_ready: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && !status.hit) |=> s_axis_tready)
    else $error("Sample without a window stalled the input.");

  a_reads_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.read_issue && status.rd_last) |=> !cmd.read_issue)
    else $error("Window read continued past its last entry.");

endmodule

[sim/tb_max_pool_2d_nhwc_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_max_pool_2d_nhwc_core
// Self-checking bench for the streaming 2-D max pooling core. A short table
// of directed samples and register writes covers the reset setting, extreme
// sample values, out-of-range registers, trailing samples and a pool larger
// than the input. Extreme tensor shapes and random tensors follow. Every
// accepted sample runs through a bench-side line store and window search,
// and each result transaction is compared against the oldest pooled value
// still owed, with random bursts on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_max_pool_2d_nhwc_core;

  localparam int DATA_W        = 16;
  localparam int IDX_W         = mp2d_pkg::CFG_INDEX_W;
  localparam int CDATA_W       = mp2d_pkg::CFG_DATA_W;
  localparam int POOL_MAX      = 4;
  localparam int WIDTH_MAX     = 128;
  localparam int CHAN_MAX      = 16;
  localparam int STORE_DEPTH   = POOL_MAX * WIDTH_MAX * CHAN_MAX;
  localparam int SETTLE_CYCLES = POOL_MAX * POOL_MAX + 8;
  localparam int RANDOM_ITEMS  = 700;
  localparam int TIMEOUT_NS    = 4_000_000;
  localparam int FIRST_SPARE   = mp2d_pkg::REG_NUM_CHANNELS + 1;
  localparam int LAST_SPARE    = (1 << IDX_W) - 1;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
  } pooled_t;

  typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [IDX_W-1:0]   index;
    logic [CDATA_W-1:0] data;
    logic [DATA_W-1:0]  sample;
    bit                 typed;
    logic [DATA_W-1:0]  exp_value;
    logic               exp_last;
  } stim_row_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [CDATA_W-1:0] cfg_data = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [DATA_W-1:0]  s_axis_tdata = '0;  // sample_value
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [DATA_W-1:0]  m_axis_tdata;       // pooled_value
  logic               m_axis_tlast;

  max_pool_2d_nhwc_core DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Bench copy of the registers, line store and position counters.
  logic [mp2d_pkg::POOL_REG_W-1:0]   pool_reg   = mp2d_pkg::POOL_RESET;
  logic [mp2d_pkg::STEP_REG_W-1:0]   step_reg   = mp2d_pkg::STEP_RESET;
  logic [mp2d_pkg::HEIGHT_REG_W-1:0] height_reg = mp2d_pkg::HEIGHT_RESET;
  logic [mp2d_pkg::WIDTH_REG_W-1:0]  width_reg  = mp2d_pkg::WIDTH_RESET;
  logic [mp2d_pkg::CHAN_REG_W-1:0]   chan_reg   = mp2d_pkg::CHAN_RESET;
  logic [DATA_W-1:0]                 line_mem [STORE_DEPTH];
  int unsigned                       row_pos = 0, col_pos = 0, chan_pos = 0;
  int unsigned                       row_ph = 0, col_ph = 0;

  pooled_t   pending_pools [$];
  stim_row_t directed_rows [$];
  int        error_count = 0;
  int        burst_left = 0;
  bit        stream_dirty = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

  function automatic int unsigned limit_reg(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic int unsigned slot_of(input int unsigned r, input int unsigned c,
                                          input int unsigned ch);
    return ((r % POOL_MAX) * WIDTH_MAX + c) * CHAN_MAX + ch;
  endfunction

  function automatic int unsigned phase_after(input int unsigned pos, input int unsigned ph,
                                              input int unsigned p, input int unsigned s);
    if (pos <= p - 1) return 0;
    return (ph + 1 >= s) ? 0 : ph + 1;
  endfunction

  function automatic logic [DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 15))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("mismatch at %0t ns: %s got %h expected %h", $time, what, got, want);
    error_count++;
  endtask

  task automatic apply_reg(input logic [IDX_W-1:0] idx, input logic [CDATA_W-1:0] d);
    if (idx <= mp2d_pkg::REG_NUM_CHANNELS) begin
      case (idx)
        mp2d_pkg::REG_POOL_SIDE: pool_reg   = d[mp2d_pkg::POOL_REG_W-1:0];
        mp2d_pkg::REG_STEP_SIZE: step_reg   = d[mp2d_pkg::STEP_REG_W-1:0];
        mp2d_pkg::REG_IN_HEIGHT: height_reg = d[mp2d_pkg::HEIGHT_REG_W-1:0];
        mp2d_pkg::REG_IN_WIDTH:  width_reg  = d[mp2d_pkg::WIDTH_REG_W-1:0];
        default:                 chan_reg   = d[mp2d_pkg::CHAN_REG_W-1:0];
      endcase
      row_pos = 0;
      col_pos = 0;
      chan_pos = 0;
      row_ph = 0;
      col_ph = 0;
    end
  endtask

  // Stores one sample and, when it closes a window, returns that window's maximum.
  task automatic window_max_step(input logic [DATA_W-1:0] x, output bit hit,
                                 output logic [DATA_W-1:0] pooled, output logic last);
    int unsigned p, s, h, w, nc;
    logic signed [DATA_W-1:0] best, v;
    p = limit_reg(pool_reg, POOL_MAX);
    s = limit_reg(step_reg, mp2d_pkg::STEP_LIMIT);
    h = limit_reg(height_reg, mp2d_pkg::HEIGHT_LIMIT);
    w = limit_reg(width_reg, WIDTH_MAX);
    nc = limit_reg(chan_reg, CHAN_MAX);
    line_mem[slot_of(row_pos, col_pos, chan_pos)] = x;
    hit = 1'b0;
    pooled = '0;
    last = 1'b0;
    if (h >= p && w >= p && row_pos >= p - 1 && col_pos >= p - 1 && row_ph == 0 &&
        col_ph == 0) begin
      best = x;
      for (int kr = 0; kr < p; kr++) begin
        for (int kc = 0; kc < p; kc++) begin
          v = line_mem[slot_of(row_pos - kr, col_pos - kc, chan_pos)];
          if (v > best) best = v;
        end
      end
      hit = 1'b1;
      pooled = best;
      last = (row_pos + s >= h) && (col_pos + s >= w) && (chan_pos == nc - 1);
    end
    chan_pos++;
    if (chan_pos >= nc) begin
      chan_pos = 0;
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        col_ph = 0;
        row_pos++;
        if (row_pos >= h) begin
          row_pos = 0;
          row_ph = 0;
        end else begin
          row_ph = phase_after(row_pos, row_ph, p, s);
        end
      end else begin
        col_ph = phase_after(col_pos, col_ph, p, s);
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_pools.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    stream_dirty = 1'b0;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CDATA_W-1:0] d);
    if (stream_dirty) wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    apply_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Writes a register value with random bits above the register's width.
  task automatic write_field(input logic [IDX_W-1:0] idx, input int unsigned v);
    int unsigned w;
    logic [CDATA_W-1:0] keep, d;
    case (idx)
      mp2d_pkg::REG_POOL_SIDE: w = mp2d_pkg::POOL_REG_W;
      mp2d_pkg::REG_STEP_SIZE: w = mp2d_pkg::STEP_REG_W;
      mp2d_pkg::REG_IN_HEIGHT: w = mp2d_pkg::HEIGHT_REG_W;
      mp2d_pkg::REG_IN_WIDTH:  w = mp2d_pkg::WIDTH_REG_W;
      default:                 w = mp2d_pkg::CHAN_REG_W;
    endcase
    keep = CDATA_W'((1 << w) - 1);
    d = CDATA_W'($urandom);
    d = (d & ~keep) | (CDATA_W'(v) & keep);
    write_reg(idx, d);
  endtask

  task automatic configure(input int unsigned p, input int unsigned s, input int unsigned h,
                           input int unsigned w, input int unsigned nc);
    write_field(mp2d_pkg::REG_POOL_SIDE, p);
    write_field(mp2d_pkg::REG_STEP_SIZE, s);
    write_field(mp2d_pkg::REG_IN_HEIGHT, h);
    write_field(mp2d_pkg::REG_IN_WIDTH, w);
    write_field(mp2d_pkg::REG_NUM_CHANNELS, nc);
  endtask

  task automatic send_sample(input logic [DATA_W-1:0] x, input bit typed,
                             input logic [DATA_W-1:0] typed_value, input logic typed_last);
    int unsigned gap;
    bit hit;
    logic [DATA_W-1:0] mx;
    logic lst;
    pooled_t owed;
    gap = 0;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 24) : $urandom_range(0, 3);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= x;
    stream_dirty = 1'b1;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    window_max_step(x, hit, mx, lst);
    if (hit) begin
      owed.value = typed ? typed_value : mx;
      owed.last = typed ? typed_last : lst;
      pending_pools.push_back(owed);
    end
  endtask

  task automatic send_random(input int unsigned n);
    repeat (n) send_sample(pick_sample(), 1'b0, '0, 1'b0);
  endtask

  task automatic row_write(input logic [IDX_W-1:0] idx, input logic [CDATA_W-1:0] d);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.index = idx;
    r.data = d;
    directed_rows.push_back(r);
  endtask

  task automatic row_sample(input logic [DATA_W-1:0] x, input bit typed,
                            input logic [DATA_W-1:0] ev, input logic el);
    stim_row_t r;
    r = '0;
    r.kind = ROW_SAMPLE;
    r.sample = x;
    r.typed = typed;
    r.exp_value = ev;
    r.exp_last = el;
    directed_rows.push_back(r);
  endtask

  always @(posedge clk) begin : result_check
    pooled_t head;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_pools.size() == 0) begin
        report_mismatch("result with nothing owed", m_axis_tdata, '0);
      end else begin
        head = pending_pools.pop_front();
        if (m_axis_tdata !== head.value) begin
          report_mismatch("pooled_value", m_axis_tdata, head.value);
        end
        if (m_axis_tlast !== head.last) begin
          report_mismatch("tlast", DATA_W'(m_axis_tlast), DATA_W'(head.last));
        end
      end
    end
  end

  initial begin : receiver
    int mode, run_len;
    forever begin
      mode = $urandom_range(0, 3);
      run_len = $urandom_range(1, 60);
      repeat (run_len) begin
        @(negedge clk);
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 7) != 0);
          default: m_axis_tready <= 1'b0;
        endcase
      end
    end
  end

  initial begin : stimulus
    int unsigned random_sent, n, tensor_len, v;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset setting: pool 2, stride 2, 8 x 8 x 1; the tenth sample closes the first window.
    row_sample(16'hFF00, 0, '0, 0);
    row_sample(16'h0080, 0, '0, 0);
    row_sample(16'h8000, 0, '0, 0);
    row_sample(16'h7FFF, 0, '0, 0);
    row_sample(16'h0001, 0, '0, 0);
    row_sample(16'hFFFF, 0, '0, 0);
    row_sample(16'h1234, 0, '0, 0);
    row_sample(16'hC000, 0, '0, 0);
    row_sample(16'h4000, 0, '0, 0);
    row_sample(16'h0000, 0, '0, 0);
    // A 1 x 1 pool passes every sample through unchanged.
    row_write(mp2d_pkg::REG_POOL_SIDE, 9'd1);
    row_write(mp2d_pkg::REG_STEP_SIZE, 9'd1);
    row_write(mp2d_pkg::REG_IN_HEIGHT, 9'd1);
    row_write(mp2d_pkg::REG_IN_WIDTH, 9'd2);
    row_write(mp2d_pkg::REG_NUM_CHANNELS, 9'd2);
    row_sample(16'h8000, 1, 16'h8000, 0);
    row_sample(16'h7FFF, 1, 16'h7FFF, 0);
    row_sample(16'h0000, 1, 16'h0000, 0);
    row_sample(16'hFFFF, 1, 16'hFFFF, 1);
    // One 2 x 2 window per channel, signed extremes mixed.
    row_write(mp2d_pkg::REG_POOL_SIDE, 9'd2);
    row_write(mp2d_pkg::REG_STEP_SIZE, 9'd2);
    row_write(mp2d_pkg::REG_IN_HEIGHT, 9'd2);
    row_sample(16'h8001, 0, '0, 0);
    row_sample(16'h7FFE, 0, '0, 0);
    row_sample(16'hFFFF, 0, '0, 0);
    row_sample(16'h8000, 0, '0, 0);
    row_sample(16'h0000, 0, '0, 0);
    row_sample(16'h8000, 0, '0, 0);
    row_sample(16'h7FFF, 0, '0, 0);
    row_sample(16'hFFFE, 0, '0, 0);
    // The pool is larger than the 2 x 2 input, so nothing comes out.
    row_write(mp2d_pkg::REG_POOL_SIDE, 9'd3);
    row_sample(16'h7FFF, 0, '0, 0);
    row_sample(16'h7FFF, 0, '0, 0);
    // Zero registers act as 1 and stride 7 as 4: one result per 1 x 3 row, the
    // rest trailing. A write to an unused index must not restart the tensor.
    row_write(mp2d_pkg::REG_POOL_SIDE, 9'd0);
    row_write(mp2d_pkg::REG_STEP_SIZE, 9'd7);
    row_write(mp2d_pkg::REG_IN_HEIGHT, 9'd0);
    row_write(mp2d_pkg::REG_IN_WIDTH, 9'd3);
    row_write(mp2d_pkg::REG_NUM_CHANNELS, 9'd0);
    row_sample(16'h0123, 1, 16'h0123, 1);
    row_sample(16'h8000, 0, '0, 0);
    row_write(IDX_W'(FIRST_SPARE), 9'h1FF);
    row_sample(16'h7FFF, 0, '0, 0);
    row_sample(16'hFF00, 1, 16'hFF00, 1);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        write_reg(directed_rows[i].index, directed_rows[i].data);
      end else begin
        send_sample(directed_rows[i].sample, directed_rows[i].typed,
                    directed_rows[i].exp_value, directed_rows[i].exp_last);
      end
    end

    // Largest shapes: full height, full width, all channels.
    configure(2, 1, (1 << mp2d_pkg::HEIGHT_REG_W) - 1, 2, 1);
    send_random(512);
    configure(4, 3, 4, (1 << mp2d_pkg::WIDTH_REG_W) - 1, 1);
    send_random(512);
    configure(4, 4, 4, 4, (1 << mp2d_pkg::CHAN_REG_W) - 1);
    send_random(256);

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      for (int i = mp2d_pkg::REG_POOL_SIDE; i <= mp2d_pkg::REG_NUM_CHANNELS; i++) begin
        if ($urandom_range(0, 3) != 0) begin
          case (i)
            mp2d_pkg::REG_POOL_SIDE, mp2d_pkg::REG_STEP_SIZE:
              v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
            mp2d_pkg::REG_IN_HEIGHT:
              v = ($urandom_range(0, 11) == 0) ?
                  $urandom_range(0, (1 << mp2d_pkg::HEIGHT_REG_W) - 1) : $urandom_range(1, 8);
            mp2d_pkg::REG_IN_WIDTH:
              v = ($urandom_range(0, 11) == 0) ?
                  $urandom_range(0, (1 << mp2d_pkg::WIDTH_REG_W) - 1) : $urandom_range(1, 8);
            default:
              v = ($urandom_range(0, 9) == 0) ?
                  $urandom_range(0, (1 << mp2d_pkg::CHAN_REG_W) - 1) : $urandom_range(1, 4);
          endcase
          write_field(i[IDX_W-1:0], v);
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        write_reg(IDX_W'($urandom_range(FIRST_SPARE, LAST_SPARE)), CDATA_W'($urandom));
      end
      tensor_len = limit_reg(height_reg, mp2d_pkg::HEIGHT_LIMIT) *
                   limit_reg(width_reg, WIDTH_MAX) * limit_reg(chan_reg, CHAN_MAX);
      if (tensor_len > 600) begin
        n = $urandom_range(1, 300);
      end else if ($urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, tensor_len);
      end else begin
        n = tensor_len * $urandom_range(1, 2);
      end
      if (n > RANDOM_ITEMS - random_sent) begin
        n = RANDOM_ITEMS - random_sent;
      end
      send_random(n);
      random_sent += n;
    end

    wait_drained();
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[max_pool_2d_nhwc_core.f]
hw/rtl/mp2d_pkg.sv
hw/rtl/mp2d_ram.sv
hw/rtl/mp2d_ctrl.sv
hw/rtl/mp2d_dp.sv
hw/rtl/max_pool_2d_nhwc_core.sv
sim/tb_max_pool_2d_nhwc_core.sv
